/* sv/tsg_pkg.sv */
// Shared types, register indexes and mode codes for the trigger shot gate.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package tsg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 120;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_INTERVAL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_JAM_THRESHOLD   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_MARGIN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOT_STEP       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_EJECT_STEP      = 3'd5;

    // Aim selector, lock status and press codes.
    localparam logic [7:0] AIM_MANUAL  = 8'd0;
    localparam logic [7:0] AIM_AUTO    = 8'd1;
    localparam logic [7:0] LOCK_LOCKED = 8'd2;
    localparam logic [7:0] PRESS_UP    = 8'd0;
    localparam logic [7:0] PRESS_DOWN  = 8'd1;

    // Drive gain selector codes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_EJECT = 2'd1;
    localparam logic [1:0] MODE_FIRE  = 2'd2;

    typedef struct packed {
        logic [31:0] manual_interval;
        logic [31:0] auto_interval;
        logic [30:0] jam_threshold;
        logic [15:0] heat_margin;
        logic [30:0] shot_step;
        logic [30:0] eject_step;
    } tsg_cfg_t;

    typedef struct packed {
        logic [31:0]        now_tick;
        logic signed [31:0] motor_angle;
        logic [7:0]         press_code;
        logic [7:0]         aim_select;
        logic [7:0]         autoaim_state;
        logic               eject_request;
        logic               fire_enable;
        logic [15:0]        heat_now;
        logic [15:0]        heat_limit;
    } tsg_item_t;

    typedef struct packed {
        logic [31:0] target;
        logic        started;
        logic [7:0]  press_now;
        logic [31:0] manual_ref;
        logic [31:0] auto_ref;
        logic        shot_pending;
        logic [1:0]  mode;
    } tsg_state_t;

    typedef struct packed {
        logic signed [31:0] target_angle;
        logic               jam_seen;
        logic               shot_fired;
        logic               ejected;
        logic [1:0]         drive_mode;
    } tsg_result_t;

endpackage

`default_nettype wire

/* sv/trigger_shot_gate.sv */
// Top level of the trigger shot gate: input register, step logic, state and result register.
// Depends on tsg_pkg, tsg_cfg_regs and tsg_step_logic.
//
// Usage:
//   The s_axis channel carries one control tick per transfer; the m_axis channel
//   returns exactly one result per tick, in order. The cfg channel writes one
//   configuration register per transfer and is always ready; write it only while
//   no tick is in flight. Indexes beyond the register list are ignored.
//   Path: an accepted tick waits in the input register, moves into the result
//   register once that register is free or being drained, and transfers on m_axis
//   when the receiver is ready.
//   Throughput: one tick per cycle while m_axis_tready stays high. The step logic
//   sits between the input register and the result register and updates the gate
//   state in the same cycle, so the next tick sees it at once.
//   Stall: while m_axis_tready is low the result holds; one more tick is still
//   taken into the input register, after which s_axis_tready drops.
//   Reset: aresetn low for one edge clears the gate state, the pipeline and the
//   configuration back to its defaults. The first tick after reset seeds the
//   target angle and both reference times.
`default_nettype none

module trigger_shot_gate
    import tsg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // now_tick[31:0], motor_angle[63:32], press_code[71:64], autoaim_state[79:72],
    // eject_request[80], fire_enable[81], heat_now[97:82], heat_limit[113:98], zeros
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // aim_select[7:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // target_angle[31:0], jam_seen[32], shot_fired[33], ejected[34],
    // drive_mode[36:35], zeros
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    tsg_cfg_t    cfg;
    tsg_item_t   item_reg;
    tsg_item_t   item_next;
    logic        in_valid_reg;
    tsg_state_t  state_reg;
    tsg_state_t  state_next;
    tsg_result_t result_next;
    tsg_result_t result_reg;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready = 1'b1;

    tsg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    tsg_step_logic u_step (
        .cfg       (cfg),
        .item      (item_reg),
        .state_cur (state_reg),
        .state_new (state_next),
        .result    (result_next)
    );

    always_comb begin
        item_next.now_tick      = s_axis_tdata[31:0];
        item_next.motor_angle   = $signed(s_axis_tdata[63:32]);
        item_next.press_code    = s_axis_tdata[71:64];
        item_next.aim_select    = s_axis_tuser[7:0];
        item_next.autoaim_state = s_axis_tdata[79:72];
        item_next.eject_request = s_axis_tdata[80];
        item_next.fire_enable   = s_axis_tdata[81];
        item_next.heat_now      = s_axis_tdata[97:82];
        item_next.heat_limit    = s_axis_tdata[113:98];
    end

    // The held tick moves on whenever the result register is free or being drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= item_next;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, result_reg.drive_mode, result_reg.ejected,
                            result_reg.shot_fired, result_reg.jam_seen,
                            result_reg.target_angle};

    a_fire_xor_eject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[33] && m_axis_tdata[34]))
        else $error("shot and ejection reported for the same tick");

    a_fire_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[33]) |-> (m_axis_tdata[36:35] == MODE_FIRE))
        else $error("shot reported without firing drive mode");

    a_eject_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[34]) |->
            (m_axis_tdata[36:35] == MODE_EJECT) && !m_axis_tdata[32])
        else $error("ejection reported with wrong mode or during a jam");

    a_state_moves_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("gate state changed without a tick moving to the result register");

endmodule

`default_nettype wire

/* sv/tsg_cfg_regs.sv */
// Configuration register file of the trigger shot gate.
// Depends on tsg_pkg for the register indexes and the register struct.
`default_nettype none

module tsg_cfg_regs
    import tsg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output tsg_cfg_t                    cfg_out
);

    tsg_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.manual_interval <= 32'd500;
            cfg_reg.auto_interval   <= 32'd800;
            cfg_reg.jam_threshold   <= 31'd2000;
            cfg_reg.heat_margin     <= 16'd100;
            cfg_reg.shot_step       <= 31'd1140;
            cfg_reg.eject_step      <= 31'd38;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MANUAL_INTERVAL: cfg_reg.manual_interval <= cfg_data;
                CFG_AUTO_INTERVAL:   cfg_reg.auto_interval   <= cfg_data;
                CFG_JAM_THRESHOLD:   cfg_reg.jam_threshold   <= cfg_data[30:0];
                CFG_HEAT_MARGIN:     cfg_reg.heat_margin     <= cfg_data[15:0];
                CFG_SHOT_STEP:       cfg_reg.shot_step       <= cfg_data[30:0];
                CFG_EJECT_STEP:      cfg_reg.eject_step      <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign cfg_out = cfg_reg;

endmodule

`default_nettype wire

/* sv/tsg_step_logic.sv */
// Combinational step of the trigger shot gate: next state and result for one tick.
// Depends on tsg_pkg for the item, state, configuration and result structs.
`default_nettype none

module tsg_step_logic
    import tsg_pkg::*;
(
    input  wire tsg_cfg_t   cfg,
    input  wire tsg_item_t  item,
    input  wire tsg_state_t state_cur,
    output tsg_state_t      state_new,
    output tsg_result_t     result
);

    logic [31:0]        angle_u;
    logic [31:0]        tgt_start;
    logic [31:0]        tgt_jam;
    logic [31:0]        lag;
    logic [31:0]        mref_start;
    logic [31:0]        aref_start;
    logic [31:0]        manual_elapsed;
    logic [31:0]        auto_elapsed;
    logic signed [17:0] heat_bound;
    logic               jam;
    logic               heat_ok;
    logic               press_edge;
    logic               manual_time_ok;
    logic               auto_time_ok;
    logic               fired;
    logic               did_eject;

    always_comb begin
        angle_u    = item.motor_angle;
        // The first tick seeds the target and both reference times.
        tgt_start  = state_cur.started ? state_cur.target     : angle_u;
        mref_start = state_cur.started ? state_cur.manual_ref : item.now_tick;
        aref_start = state_cur.started ? state_cur.auto_ref   : item.now_tick;

        lag     = tgt_start - angle_u;
        jam     = $signed({lag[31], lag}) > $signed({2'b00, cfg.jam_threshold});
        tgt_jam = jam ? angle_u : tgt_start;

        heat_bound = $signed({2'b00, item.heat_limit}) - $signed({2'b00, cfg.heat_margin});
        heat_ok    = $signed({2'b00, item.heat_now}) < heat_bound;
        press_edge = (state_cur.press_now == PRESS_UP) && (item.press_code == PRESS_DOWN);

        manual_elapsed = item.now_tick - mref_start;
        auto_elapsed   = item.now_tick - aref_start;
        manual_time_ok = manual_elapsed > cfg.manual_interval;
        auto_time_ok   = auto_elapsed > cfg.auto_interval;

        state_new              = state_cur;
        state_new.started      = 1'b1;
        state_new.press_now    = item.press_code;
        state_new.manual_ref   = mref_start;
        state_new.auto_ref     = aref_start;
        state_new.target       = tgt_jam;
        fired                  = 1'b0;
        did_eject              = 1'b0;

        unique case (item.aim_select)
            AIM_MANUAL: begin
                // A pending shot is retired once its interval has run out.
                if (manual_time_ok && state_cur.shot_pending) begin
                    state_new.manual_ref   = item.now_tick;
                    state_new.shot_pending = 1'b0;
                end
                if (press_edge && !jam && !item.eject_request && heat_ok
                        && manual_time_ok && item.fire_enable) begin
                    state_new.target       = tgt_jam + {1'b0, cfg.shot_step};
                    state_new.mode         = MODE_FIRE;
                    state_new.shot_pending = 1'b1;
                    fired                  = 1'b1;
                end else if (press_edge && !jam && item.eject_request) begin
                    state_new.target = tgt_jam - {1'b0, cfg.eject_step};
                    state_new.mode   = MODE_EJECT;
                    did_eject        = 1'b1;
                end
            end
            AIM_AUTO: begin
                if (item.autoaim_state == LOCK_LOCKED) begin
                    state_new.mode = MODE_FIRE;
                    if (auto_time_ok && state_cur.shot_pending) begin
                        state_new.auto_ref     = item.now_tick;
                        state_new.shot_pending = 1'b0;
                    end
                    if (auto_time_ok && !jam && (item.press_code == PRESS_DOWN)
                            && item.fire_enable) begin
                        state_new.target       = tgt_jam + {1'b0, cfg.shot_step};
                        state_new.shot_pending = 1'b1;
                        fired                  = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        result.target_angle = state_new.target;
        result.jam_seen     = jam;
        result.shot_fired   = fired;
        result.ejected      = did_eject;
        result.drive_mode   = state_new.mode;
    end

endmodule

`default_nettype wire
